### hw/rtl/tkl_pkg.sv
// Package for the top-k largest product block: widths, reset values and the
// link type that joins neighboring cells of the sorted chain.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tkl_pkg;

  localparam int unsigned VALUE_W      = 16;
  localparam int unsigned PROD_W       = 32;
  localparam int unsigned KEEP_W       = 5;
  localparam int unsigned MAX_KEEP_DEF = 16;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd2;

  // What one cell hands to the cell below it during an insertion.
  typedef struct packed {
    logic               take;
    logic [VALUE_W-1:0] val;
  } tkl_link_t;

  // Control of the product accumulator.
  typedef struct packed {
    logic start;
    logic step;
  } tkl_mul_ctrl_t;

endpackage

### hw/rtl/tkl_cell.sv
// One cell of the descending sorted chain of kept values.
// Depends on tkl_pkg for the value width and the link type.
`timescale 1ns / 1ps

module tkl_cell (
  input  logic                        clk_i,
  input  logic                        ins_i,
  input  logic                        shift_up_i,
  input  logic                        valid_i,
  input  logic [tkl_pkg::VALUE_W-1:0] value_i,
  input  tkl_pkg::tkl_link_t          prev_i,
  input  logic [tkl_pkg::VALUE_W-1:0] next_val_i,
  output tkl_pkg::tkl_link_t          link_o,
  output logic                        hit_o
);
  import tkl_pkg::*;

  logic [VALUE_W-1:0] val_d, val_q;
  logic               greater;
  logic               take;

  // The chain is sorted in descending order, so the cells that take part in
  // an insertion form a contiguous run at the tail of the valid entries.
  assign greater = value_i > val_q;
  assign take    = ins_i && (!valid_i || greater);
  assign hit_o   = valid_i && greater;

  always_comb begin
    val_d = val_q;
    if (shift_up_i) begin
      val_d = next_val_i;
    end else if (take) begin
      val_d = prev_i.take ? prev_i.val : value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o.take = take;
  assign link_o.val  = val_q;

endmodule

### hw/rtl/tkl_mul.sv
// Product accumulator: multiplies in one kept value per step and tracks the
// overflow and zero flags. Depends on tkl_pkg for widths and the control type.
`timescale 1ns / 1ps

module tkl_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tkl_pkg::tkl_mul_ctrl_t      ctrl_i,
  input  logic [tkl_pkg::VALUE_W-1:0] operand_i,
  output logic [tkl_pkg::PROD_W-1:0]  product_o,
  output logic                        overflow_o
);
  import tkl_pkg::*;

  localparam int unsigned WideW = PROD_W + VALUE_W;

  logic [PROD_W-1:0] prod_d, prod_q;
  logic              over_d, over_q;
  logic              zero_d, zero_q;
  logic [WideW-1:0]  wide;

  assign wide = WideW'(prod_q) * WideW'(operand_i);

  always_comb begin
    prod_d = prod_q;
    over_d = over_q;
    zero_d = zero_q;
    if (ctrl_i.start) begin
      prod_d = PROD_W'(1);
      over_d = 1'b0;
      zero_d = 1'b0;
    end else if (ctrl_i.step) begin
      prod_d = wide[PROD_W-1:0];
      over_d = over_q || (wide[WideW-1:PROD_W] != '0);
      zero_d = zero_q || (operand_i == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= PROD_W'(1);
      over_q <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      prod_q <= prod_d;
      over_q <= over_d;
      zero_q <= zero_d;
    end
  end

  // A zero factor makes the exact product zero, which never overflows.
  assign product_o  = prod_q;
  assign overflow_o = over_q && !zero_q;

endmodule

### hw/rtl/top_k_largest_product.sv
// Top level of the top-k largest product block: sorted cell chain, product
// accumulator and the control that sequences them.
// Depends on tkl_pkg, tkl_cell and tkl_mul.
`timescale 1ns / 1ps

// Usage
//   Values of one set arrive on the input channel (value_i, is_last_i) with a
//   valid/ready handshake. Each transfer inserts the value into a chain of
//   cells that is kept sorted in descending order, and after an item that
//   does not end the set the next one may follow directly.
//   When fewer than keep_count values are kept the value is added; otherwise
//   it replaces the smallest kept value if it is strictly greater.
//   A transfer with is_last_i high ends the set. The chain then shifts its
//   kept values, one per cycle, into a single 32x16 multiplier; in_ready_o
//   is low meanwhile. The result (product_o modulo 2^32 and overflow_o)
//   is loaded into an output register and offered on the output channel;
//   a new set is accepted while that result still waits for its transfer.
//   If the receiver stalls and a second result is due, the block holds at
//   the end of the drain until the output register is free.
//   keep_count is written through cfg_we_i/cfg_wdata_i while the block is
//   idle; values above MaxKeep act as MaxKeep, and zero gives product 1.
//   Reset empties the chain, sets keep_count to 2 and clears the output.
module top_k_largest_product #(
  parameter int unsigned MaxKeep = tkl_pkg::MAX_KEEP_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tkl_pkg::KEEP_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tkl_pkg::VALUE_W-1:0] value_i,
  input  logic                        is_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tkl_pkg::PROD_W-1:0]  product_o,
  output logic                        overflow_o
);
  import tkl_pkg::*;

  localparam int unsigned CntW = $clog2(MaxKeep + 1);
  localparam int unsigned CmpW = (CntW > KEEP_W) ? CntW : KEEP_W;

  typedef enum logic [0:0] {
    S_ACCEPT,
    S_DRAIN
  } state_e;

  state_e            state_d, state_q;
  logic [KEEP_W-1:0] keep_d, keep_q;
  logic [CntW-1:0]   total_d, total_q;
  logic [CntW-1:0]   cnt_d, cnt_q;
  logic              out_valid_d, out_valid_q;
  logic [PROD_W-1:0] product_d, product_q;
  logic              overflow_d, overflow_q;

  logic [CmpW-1:0]    eff_keep;
  logic               below_keep;
  logic               in_fire;
  logic               ins;
  logic               step;
  logic               finish;
  logic [MaxKeep-1:0] valid;
  logic [MaxKeep-1:0] hit;
  tkl_link_t          links [MaxKeep];
  tkl_mul_ctrl_t      mul_ctrl;
  logic [PROD_W-1:0]  mul_product;
  logic               mul_overflow;

  // Keep counts above the chain length saturate to the chain length.
  assign eff_keep   = (CmpW'(keep_q) > CmpW'(MaxKeep)) ? CmpW'(MaxKeep) : CmpW'(keep_q);
  assign below_keep = CmpW'(total_q) < eff_keep;

  assign in_ready_o = (state_q == S_ACCEPT);
  assign in_fire    = in_valid_i && in_ready_o;

  // Because the chain is sorted, a value beats the smallest kept value
  // exactly when it beats any kept value.
  assign ins    = in_fire && (below_keep || (|hit));
  assign step   = (state_q == S_DRAIN) && (cnt_q != '0);
  assign finish = (state_q == S_DRAIN) && (cnt_q == '0) && (!out_valid_q || out_ready_i);

  for (genvar i = 0; i < MaxKeep; i++) begin : g_cell
    tkl_link_t          prev;
    logic [VALUE_W-1:0] next_val;

    assign valid[i] = CntW'(i) < total_q;

    if (i == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = links[i-1];
    end

    if (i == MaxKeep - 1) begin : g_tail
      assign next_val = '0;
    end else begin : g_inner
      assign next_val = links[i+1].val;
    end

    tkl_cell u_cell (
      .clk_i      (clk_i),
      .ins_i      (ins),
      .shift_up_i (step),
      .valid_i    (valid[i]),
      .value_i    (value_i),
      .prev_i     (prev),
      .next_val_i (next_val),
      .link_o     (links[i]),
      .hit_o      (hit[i])
    );
  end

  assign mul_ctrl.start = in_fire && is_last_i;
  assign mul_ctrl.step  = step;

  tkl_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mul_ctrl),
    .operand_i  (links[0].val),
    .product_o  (mul_product),
    .overflow_o (mul_overflow)
  );

  always_comb begin
    state_d     = state_q;
    keep_d      = keep_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    product_d   = product_q;
    overflow_d  = overflow_q;

    if (cfg_we_i) begin
      keep_d = cfg_wdata_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_ACCEPT: begin
        if (in_fire) begin
          if (below_keep) begin
            total_d = total_q + 1'b1;
          end
          if (is_last_i) begin
            cnt_d   = total_d;
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (step) begin
          cnt_d = cnt_q - 1'b1;
        end else if (finish) begin
          out_valid_d = 1'b1;
          product_d   = mul_product;
          overflow_d  = mul_overflow;
          total_d     = '0;
          state_d     = S_ACCEPT;
        end
      end
      default: begin
        state_d = S_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACCEPT;
      keep_q      <= KEEP_RESET;
      total_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      product_q   <= '0;
      overflow_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      keep_q      <= keep_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      product_q   <= product_d;
      overflow_q  <= overflow_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign product_o   = product_q;
  assign overflow_o  = overflow_q;

  // The chain never holds more values than it has cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(total_q) <= CmpW'(MaxKeep))
    else $error("kept total exceeds chain length");

  // A transfer grows the kept total by at most one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (total_q == $past(total_q)) || (total_q == $past(total_q) + 1'b1))
    else $error("kept total jumped on an insertion");

  // The end of a set always starts the drain of the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_last_i) |=> (state_q == S_DRAIN) && (cnt_q == total_q))
    else $error("drain did not start with the kept total");

  // The drain count never runs past the kept values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> (cnt_q <= total_q))
    else $error("drain count beyond kept total");

  // Valid cells stay in descending order while the chain takes values; the
  // drain shifts stale cells into the valid range, so it is not checked there.
  for (genvar k = 1; k < MaxKeep; k++) begin : g_order_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      ((state_q == S_ACCEPT) && valid[k]) |-> (links[k-1].val >= links[k].val))
      else $error("cell chain out of order");
  end

endmodule

### bench/tkl_product_checker.sv
// Checker for the top-k largest product block: watches the register port and
// both valid/ready channels, predicts each set result and compares it.
// Depends on tkl_pkg for widths and the keep_count reset value.
`timescale 1ns / 1ps

module tkl_product_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tkl_pkg::KEEP_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [tkl_pkg::VALUE_W-1:0] value_i,
  input  logic                        is_last_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [tkl_pkg::PROD_W-1:0]  product_i,
  input  logic                        overflow_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);

  localparam int unsigned StoreDepth = tkl_pkg::MAX_KEEP_DEF;

  typedef struct packed {
    logic [tkl_pkg::PROD_W-1:0] product;
    logic                       overflow;
  } set_result_t;

  logic [tkl_pkg::KEEP_W-1:0]  keep_count;
  logic [tkl_pkg::VALUE_W-1:0] largest_vals [StoreDepth];
  int unsigned                 largest_n;
  set_result_t                 awaited_products [$];
  int unsigned                 mismatches;

  // Adds one value to the kept set, then closes the set on its last value.
  task automatic take_value(input logic [tkl_pkg::VALUE_W-1:0] v, input logic last);
    int unsigned limit;
    int unsigned low_pos;
    logic [63:0] wide;
    logic [tkl_pkg::PROD_W-1:0] acc;
    logic over;
    logic saw_zero;
    set_result_t res;
    limit = (keep_count > StoreDepth) ? StoreDepth : keep_count;
    if (largest_n < limit) begin
      largest_vals[largest_n] = v;
      largest_n++;
    end else if (largest_n != 0) begin
      low_pos = 0;
      for (int unsigned i = 1; i < largest_n; i++) begin
        if (largest_vals[i] < largest_vals[low_pos]) low_pos = i;
      end
      if (v > largest_vals[low_pos]) largest_vals[low_pos] = v;
    end
    if (last) begin
      acc = 1;
      over = 1'b0;
      saw_zero = 1'b0;
      for (int unsigned i = 0; i < largest_n; i++) begin
        wide = {32'd0, acc} * {48'd0, largest_vals[i]};
        if (largest_vals[i] == 0) saw_zero = 1'b1;
        if (wide[63:32] != 0) over = 1'b1;
        acc = wide[31:0];
      end
      res.product = acc;
      res.overflow = over && !saw_zero;
      awaited_products = {awaited_products, res};
      largest_n = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    set_result_t want;
    if (!rst_ni) begin
      keep_count = tkl_pkg::KEEP_RESET;
      largest_n = 0;
      mismatches = 0;
      awaited_products.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) keep_count = cfg_wdata_i;
      if (in_valid_i && in_ready_i) take_value(value_i, is_last_i);
      if (out_valid_i && out_ready_i) begin
        if (awaited_products.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result %h/%0b arrived with none expected",
                     $realtime, product_i, overflow_i);
          mismatches++;
        end else begin
          want = awaited_products.pop_front();
          if (product_i !== want.product || overflow_i !== want.overflow) begin
            if (mismatches < 10)
              $display("%0t: result mismatch: expected product %h overflow %0b, got %h %0b",
                       $realtime, want.product, want.overflow, product_i, overflow_i);
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o <= awaited_products.size();
    end
  end

endmodule

### bench/top_k_largest_product_tb.sv
// Testbench top for top_k_largest_product: makes stimulus and stalls on both
// channels, writes keep_count between phases and gives the final verdict.
// Depends on tkl_pkg, top_k_largest_product and tkl_product_checker.
`timescale 1ns / 1ps

module top_k_largest_product_tb;

  // Cycle budget: far above the slowest correct run, including the long holds.
  localparam int unsigned CycleLimit = 1000000;
  // Idle cycles before a register write, covering a set end with a full store.
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned RandomItems = 1850;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [tkl_pkg::KEEP_W-1:0]  cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [tkl_pkg::VALUE_W-1:0] value = '0;
  logic                        is_last = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [tkl_pkg::PROD_W-1:0]  product;
  logic                        overflow;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  // When set, neither side makes random idles, so back-to-back transfers happen too.
  logic        calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  top_k_largest_product dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .value_i     (value),
    .is_last_i   (is_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .product_o   (product),
    .overflow_o  (overflow)
  );

  tkl_product_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .value_i      (value),
    .is_last_i    (is_last),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .product_i    (product),
    .overflow_i   (overflow),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Values lean toward the edges: zero, tiny values and values near the top
  // of the range, so that both overflow outcomes and the zero case come up.
  function automatic logic [tkl_pkg::VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 15) return tkl_pkg::VALUE_W'($urandom_range(1, 15));
    if (r < 25) return tkl_pkg::VALUE_W'($urandom_range(65280, 65535));
    return tkl_pkg::VALUE_W'($urandom());
  endfunction

  // Offers one value after a random gap and returns at the edge of its
  // transfer. Valid stays high into the next call when that call has no gap,
  // so it is never lowered and raised in the same time step.
  task automatic send_value(input logic [tkl_pkg::VALUE_W-1:0] v, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    is_last <= last;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Sends len random values; the final one closes the set only when closed.
  task automatic send_set(input int unsigned len, input logic closed);
    calm <= ($urandom_range(0, 5) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      send_value(pick_value(), closed && (i == len - 1));
    end
  endtask

  // Writes keep_count once the block is idle: no result outstanding, and
  // enough further cycles for a set end or an insertion still in progress.
  task automatic write_keep(input logic [tkl_pkg::KEEP_W-1:0] k);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, plus two long holds started after a given number
  // of results. During a hold the sender keeps offering values, so finished
  // sets pile up and the block has to stall its input.
  always @(posedge clk) begin : receiver
    int unsigned hold_left;
    int unsigned taken;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
      taken = 0;
    end else begin
      if (out_valid && out_ready) begin
        taken++;
        if (taken == 40 || taken == 250) hold_left = 400;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) hold_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [tkl_pkg::KEEP_W-1:0] k;
    int unsigned kept_max;
    int unsigned r;
    int unsigned len;
    logic partial;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset keep_count of two: the two largest full-scale values are kept,
    // which is the largest product that still fits in 32 bits.
    send_value(16'd1, 1'b0);
    send_value(16'hFFFF, 1'b0);
    send_value(16'hFFFF, 1'b1);
    // A zero among the kept values gives product zero without overflow.
    send_value(16'h0000, 1'b1);

    // Keep count zero: nothing is kept and the product is one.
    write_keep(5'd0);
    send_value(16'd40000, 1'b1);

    // Keep count above the store depth acts as the depth. Sixteen values are
    // kept, so the closing three replaces one of the equal smallest twos, and
    // the product still fits in 32 bits without overflow.
    write_keep(5'd31);
    for (int unsigned i = 0; i < 15; i++) send_value(16'd2, 1'b0);
    send_value(16'hFFFF, 1'b0);
    send_value(16'd3, 1'b1);

    // Keep count lowered in the middle of a set: the three values already
    // kept stay, a smaller value is dropped and a larger one replaces the
    // smallest kept value.
    write_keep(5'd3);
    send_value(16'd100, 1'b0);
    send_value(16'd200, 1'b0);
    send_value(16'd300, 1'b0);
    write_keep(5'd1);
    send_value(16'd50, 1'b0);
    send_value(16'd150, 1'b1);

    // Random phases, each with its own keep_count. Some phases stop in the
    // middle of a set, so the next write changes keep_count within a set.
    while (sent < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 10) k = 5'd0;
      else if (r < 20) k = 5'd1;
      else if (r < 35) k = 5'd16;
      else if (r < 45) k = tkl_pkg::KEEP_W'($urandom_range(17, 31));
      else k = tkl_pkg::KEEP_W'($urandom_range(2, 8));
      write_keep(k);
      kept_max = (k > tkl_pkg::MAX_KEEP_DEF) ? tkl_pkg::MAX_KEEP_DEF : k;
      repeat ($urandom_range(3, 20)) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, kept_max + 3);
        else if (r < 95) len = $urandom_range(1, 4);
        else len = $urandom_range(10, 30);
        send_set(len, 1'b1);
      end
      partial = ($urandom_range(0, 3) == 0);
      if (partial) send_set($urandom_range(1, 5), 1'b0);
    end
    // Close whatever set is still open so that no values are left behind.
    send_value(pick_value(), 1'b1);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
